// ----- src/qau_pkg.sv -----
// Shared constants for the quaternion arithmetic unit: action codes,
// component indices and default fixed-point format.
// No dependencies.
package qau_pkg;

    localparam int DEF_FRAC_BITS  = 14;
    localparam int DEF_COMP_WIDTH = 16;

    localparam int ACT_W    = 3;
    localparam int NUM_COMP = 4;

    // component order x, y, z, w
    localparam int CX = 0;
    localparam int CY = 1;
    localparam int CZ = 2;
    localparam int CW = 3;

    localparam logic [ACT_W-1:0] ACT_MUL  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ROT  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_IROT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DOT  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CONJ = 3'd4;

endpackage

// ----- src/qau_qmul.sv -----
// Three-stage pipelined Hamilton product r = p * q with round-to-nearest
// and saturation of each component. Stages: products, sums, finish.
// Depends on qau_pkg.
module qau_qmul #(
    parameter int OPW  = qau_pkg::DEF_COMP_WIDTH + 1,
    parameter int FRAC = qau_pkg::DEF_FRAC_BITS,
    parameter int W    = qau_pkg::DEF_COMP_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic signed [OPW-1:0] p [qau_pkg::NUM_COMP],
    input  logic signed [OPW-1:0] q [qau_pkg::NUM_COMP],
    output logic                  out_valid,
    output logic signed [W-1:0]   r [qau_pkg::NUM_COMP]
);
    import qau_pkg::*;

    localparam int PRW  = 2 * OPW;
    localparam int ACCW = PRW + 2;

    localparam logic signed [ACCW-1:0] HALF =
        {{(ACCW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
    localparam logic signed [ACCW-1:0] SAT_MAX =
        {{(ACCW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [ACCW-1:0] SAT_MIN =
        {{(ACCW-W+1){1'b1}}, {(W-1){1'b0}}};

    logic signed [PRW-1:0]  prod_reg  [NUM_COMP][NUM_COMP];
    logic signed [PRW-1:0]  prod_next [NUM_COMP][NUM_COMP];
    logic signed [ACCW-1:0] acc_reg   [NUM_COMP];
    logic signed [ACCW-1:0] acc_next  [NUM_COMP];
    logic signed [ACCW-1:0] shr       [NUM_COMP];
    logic signed [W-1:0]    r_reg     [NUM_COMP];
    logic signed [W-1:0]    r_next    [NUM_COMP];
    logic                   v_prod_reg;
    logic                   v_acc_reg;
    logic                   v_out_reg;

    // term order per lane matches the sign pattern in the sum stage
    always_comb
    begin
        prod_next[CX][0] = PRW'(p[CW]) * PRW'(q[CX]);
        prod_next[CX][1] = PRW'(p[CX]) * PRW'(q[CW]);
        prod_next[CX][2] = PRW'(p[CY]) * PRW'(q[CZ]);
        prod_next[CX][3] = PRW'(p[CZ]) * PRW'(q[CY]);

        prod_next[CY][0] = PRW'(p[CW]) * PRW'(q[CY]);
        prod_next[CY][1] = PRW'(p[CX]) * PRW'(q[CZ]);
        prod_next[CY][2] = PRW'(p[CY]) * PRW'(q[CW]);
        prod_next[CY][3] = PRW'(p[CZ]) * PRW'(q[CX]);

        prod_next[CZ][0] = PRW'(p[CW]) * PRW'(q[CZ]);
        prod_next[CZ][1] = PRW'(p[CX]) * PRW'(q[CY]);
        prod_next[CZ][2] = PRW'(p[CY]) * PRW'(q[CX]);
        prod_next[CZ][3] = PRW'(p[CZ]) * PRW'(q[CW]);

        prod_next[CW][0] = PRW'(p[CW]) * PRW'(q[CW]);
        prod_next[CW][1] = PRW'(p[CX]) * PRW'(q[CX]);
        prod_next[CW][2] = PRW'(p[CY]) * PRW'(q[CY]);
        prod_next[CW][3] = PRW'(p[CZ]) * PRW'(q[CZ]);
    end

    always_comb
    begin
        acc_next[CX] = ACCW'(prod_reg[CX][0]) + ACCW'(prod_reg[CX][1])
                     + ACCW'(prod_reg[CX][2]) - ACCW'(prod_reg[CX][3]) + HALF;
        acc_next[CY] = ACCW'(prod_reg[CY][0]) - ACCW'(prod_reg[CY][1])
                     + ACCW'(prod_reg[CY][2]) + ACCW'(prod_reg[CY][3]) + HALF;
        acc_next[CZ] = ACCW'(prod_reg[CZ][0]) + ACCW'(prod_reg[CZ][1])
                     - ACCW'(prod_reg[CZ][2]) + ACCW'(prod_reg[CZ][3]) + HALF;
        acc_next[CW] = ACCW'(prod_reg[CW][0]) - ACCW'(prod_reg[CW][1])
                     - ACCW'(prod_reg[CW][2]) - ACCW'(prod_reg[CW][3]) + HALF;
    end

    always_comb
    begin
        for (int i = 0; i < NUM_COMP; i++)
        begin
            shr[i] = acc_reg[i] >>> FRAC;
            if (shr[i] > SAT_MAX)
            begin
                r_next[i] = SAT_MAX[W-1:0];
            end
            else if (shr[i] < SAT_MIN)
            begin
                r_next[i] = SAT_MIN[W-1:0];
            end
            else
            begin
                r_next[i] = shr[i][W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        r_reg    <= r_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_prod_reg <= 1'b0;
            v_acc_reg  <= 1'b0;
            v_out_reg  <= 1'b0;
        end
        else
        begin
            v_prod_reg <= in_valid;
            v_acc_reg  <= v_prod_reg;
            v_out_reg  <= v_acc_reg;
        end
    end

    assign out_valid = v_out_reg;
    assign r         = r_reg;

endmodule

// ----- src/quaternion_arithmetic_unit.sv -----
// Top level of the quaternion arithmetic unit: input register, two chained
// Hamilton product pipelines, side delay lines and the result register.
// Depends on qau_pkg and qau_qmul.
//
// Usage:
//   Drive action, ax..aw, bx..bw and raise start; the beat is taken at a
//   rising edge where start is high and busy is low. Actions: multiply a*b,
//   rotate (bx,by,bz) by a*v*conj(a), inverse rotate conj(a)*v*a, dot
//   product into rw, conjugate of a; other codes give zeros.
//   Each result shows on rx, ry, rz, rw for one cycle with done high.
//   Throughput is one beat per cycle while busy is low: input register,
//   two 3-stage product pipelines (products, sums, round and saturate)
//   and the output register are all fully pipelined.
//   Reset clears every valid bit and holds busy high; busy drops in the
//   cycle after reset is released and stays low. The receiver cannot
//   stall, so results are never held back and nothing is buffered.
module quaternion_arithmetic_unit #(
    parameter int FRAC_BITS  = qau_pkg::DEF_FRAC_BITS,
    parameter int COMP_WIDTH = qau_pkg::DEF_COMP_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [qau_pkg::ACT_W-1:0]    action,
    input  logic signed [COMP_WIDTH-1:0] ax,
    input  logic signed [COMP_WIDTH-1:0] ay,
    input  logic signed [COMP_WIDTH-1:0] az,
    input  logic signed [COMP_WIDTH-1:0] aw,
    input  logic signed [COMP_WIDTH-1:0] bx,
    input  logic signed [COMP_WIDTH-1:0] by,
    input  logic signed [COMP_WIDTH-1:0] bz,
    input  logic signed [COMP_WIDTH-1:0] bw,
    output logic                         done,
    output logic signed [COMP_WIDTH-1:0] rx,
    output logic signed [COMP_WIDTH-1:0] ry,
    output logic signed [COMP_WIDTH-1:0] rz,
    output logic signed [COMP_WIDTH-1:0] rw
);
    import qau_pkg::*;

    localparam int W      = COMP_WIDTH;
    localparam int OPW    = COMP_WIDTH + 1;
    localparam int MUL_D  = 3;
    localparam int SIDE_D = 2 * MUL_D;

    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

    logic                   busy_reg;
    logic                   accept;
    logic                   v_in_reg;
    logic [ACT_W-1:0]       act_in_reg;
    logic signed [W-1:0]    a_in_reg [NUM_COMP];
    logic signed [W-1:0]    b_in_reg [NUM_COMP];

    logic signed [OPW-1:0]  a_ext  [NUM_COMP];
    logic signed [OPW-1:0]  ac_ext [NUM_COMP];
    logic signed [OPW-1:0]  b_ext  [NUM_COMP];
    logic signed [OPW-1:0]  v_ext  [NUM_COMP];
    logic signed [OPW-1:0]  p1     [NUM_COMP];
    logic signed [OPW-1:0]  q1     [NUM_COMP];
    logic signed [OPW-1:0]  q2_src [NUM_COMP];
    logic signed [W-1:0]    conj_next [NUM_COMP];

    logic [ACT_W-1:0]       act_dly_reg  [SIDE_D];
    logic signed [W-1:0]    conj_dly_reg [SIDE_D][NUM_COMP];
    logic signed [OPW-1:0]  q2_dly_reg   [MUL_D][NUM_COMP];
    logic signed [W-1:0]    r1_dly_reg   [MUL_D][NUM_COMP];

    logic                   v1;
    logic signed [W-1:0]    r1 [NUM_COMP];
    logic signed [OPW-1:0]  p2 [NUM_COMP];
    logic                   v2;
    logic signed [W-1:0]    r2 [NUM_COMP];

    logic                   done_reg;
    logic signed [W-1:0]    res_reg  [NUM_COMP];
    logic signed [W-1:0]    res_next [NUM_COMP];

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            v_in_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            v_in_reg <= accept;
            done_reg <= v2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_in_reg   <= action;
            a_in_reg[CX] <= ax;
            a_in_reg[CY] <= ay;
            a_in_reg[CZ] <= az;
            a_in_reg[CW] <= aw;
            b_in_reg[CX] <= bx;
            b_in_reg[CY] <= by;
            b_in_reg[CZ] <= bz;
            b_in_reg[CW] <= bw;
        end
    end

    // operand setup; conj(a) kept one bit wider so negating the minimum is exact
    always_comb
    begin
        for (int i = 0; i < NUM_COMP; i++)
        begin
            a_ext[i] = OPW'(a_in_reg[i]);
            b_ext[i] = OPW'(b_in_reg[i]);
            if (i == CW)
            begin
                ac_ext[i]    = a_ext[i];
                v_ext[i]     = '0;
                conj_next[i] = a_in_reg[i];
            end
            else
            begin
                ac_ext[i]    = -a_ext[i];
                v_ext[i]     = b_ext[i];
                conj_next[i] = (a_in_reg[i] == CMIN) ? CMAX : -a_in_reg[i];
            end
        end

        unique case (act_in_reg)
            ACT_ROT:
            begin
                p1 = a_ext;
                q1 = v_ext;
            end
            ACT_IROT:
            begin
                p1 = ac_ext;
                q1 = v_ext;
            end
            // conj(a)*b has the full dot product in its real part
            ACT_DOT:
            begin
                p1 = ac_ext;
                q1 = b_ext;
            end
            default:
            begin
                p1 = a_ext;
                q1 = b_ext;
            end
        endcase

        if (act_in_reg == ACT_IROT)
        begin
            q2_src = a_ext;
        end
        else
        begin
            q2_src = ac_ext;
        end
    end

    qau_qmul #(
        .OPW  (OPW),
        .FRAC (FRAC_BITS),
        .W    (W)
    ) u_mul1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_in_reg),
        .p         (p1),
        .q         (q1),
        .out_valid (v1),
        .r         (r1)
    );

    always_ff @(posedge clk)
    begin
        act_dly_reg[0]  <= act_in_reg;
        conj_dly_reg[0] <= conj_next;
        q2_dly_reg[0]   <= q2_src;
        r1_dly_reg[0]   <= r1;
        for (int k = 1; k < SIDE_D; k++)
        begin
            act_dly_reg[k]  <= act_dly_reg[k-1];
            conj_dly_reg[k] <= conj_dly_reg[k-1];
        end
        for (int k = 1; k < MUL_D; k++)
        begin
            q2_dly_reg[k] <= q2_dly_reg[k-1];
            r1_dly_reg[k] <= r1_dly_reg[k-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_COMP; i++)
        begin
            p2[i] = OPW'(r1[i]);
        end
    end

    qau_qmul #(
        .OPW  (OPW),
        .FRAC (FRAC_BITS),
        .W    (W)
    ) u_mul2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .p         (p2),
        .q         (q2_dly_reg[MUL_D-1]),
        .out_valid (v2),
        .r         (r2)
    );

    always_comb
    begin
        for (int i = 0; i < NUM_COMP; i++)
        begin
            res_next[i] = '0;
        end
        unique case (act_dly_reg[SIDE_D-1]) inside
            ACT_MUL:
            begin
                res_next = r1_dly_reg[MUL_D-1];
            end
            ACT_ROT, ACT_IROT:
            begin
                res_next[CX] = r2[CX];
                res_next[CY] = r2[CY];
                res_next[CZ] = r2[CZ];
            end
            ACT_DOT:
            begin
                res_next[CW] = r1_dly_reg[MUL_D-1][CW];
            end
            ACT_CONJ:
            begin
                res_next = conj_dly_reg[SIDE_D-1];
            end
            default:
            begin
                res_next[CW] = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign rx   = res_reg[CX];
    assign ry   = res_reg[CY];
    assign rz   = res_reg[CZ];
    assign rw   = res_reg[CW];

    // every result traces back to an earlier accepted input beat
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 8))
        else $error("result without a matching input beat");

    a_rot_real_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(accept, 8) &&
         ($past(action, 8) == ACT_ROT || $past(action, 8) == ACT_IROT)) |-> rw == '0)
        else $error("rotation result has nonzero real part");

    a_dot_vec_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(accept, 8) && $past(action, 8) == ACT_DOT)
        |-> (rx == '0 && ry == '0 && rz == '0))
        else $error("dot result has nonzero vector part");

endmodule

// ----- tb/quaternion_arithmetic_unit_tb.sv -----
// Self-checking testbench for quaternion_arithmetic_unit: directed and random beats,
// with every result checked against a fixed-point quaternion predictor in this file.
// Depends on qau_pkg and the quaternion_arithmetic_unit RTL.
module quaternion_arithmetic_unit_tb;

    import qau_pkg::*;

    localparam int COMP  = DEF_COMP_WIDTH;
    localparam int FRAC  = DEF_FRAC_BITS;
    localparam int Q_ONE = 1 << FRAC;
    localparam int Q_MAX = (1 << (COMP - 1)) - 1;
    localparam int Q_MIN = -(1 << (COMP - 1));
    localparam int COS45 = 11585;

    localparam longint COMP_MAX = (longint'(1) << (COMP - 1)) - 1;
    localparam longint COMP_MIN = -(longint'(1) << (COMP - 1));

    // codes the block leaves unused
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_MID = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS  = 1600;
    localparam int MAX_GAP       = 13;
    localparam int DRAIN_CYCLES  = 24;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [ACT_W-1:0] op;
        logic [COMP-1:0]  ax;
        logic [COMP-1:0]  ay;
        logic [COMP-1:0]  az;
        logic [COMP-1:0]  aw;
        logic [COMP-1:0]  bx;
        logic [COMP-1:0]  by;
        logic [COMP-1:0]  bz;
        logic [COMP-1:0]  bw;
    } item_t;

    typedef struct packed {
        logic [COMP-1:0] x;
        logic [COMP-1:0] y;
        logic [COMP-1:0] z;
        logic [COMP-1:0] w;
    } quat_res_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [ACT_W-1:0]        action;
    logic signed [COMP-1:0]  ax, ay, az, aw;
    logic signed [COMP-1:0]  bx, by, bz, bw;
    logic                    done;
    logic signed [COMP-1:0]  rx, ry, rz, rw;

    item_t     pending_beats[$];
    quat_res_t expected_quats[$];

    logic taken;
    int   gap_left;
    bit   burst_mode;
    int   idle_cycles;
    int   beats_taken;
    int   results_checked;
    int   mismatches;
    int   action_count[8];

    quaternion_arithmetic_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .action (action),
        .ax     (ax),
        .ay     (ay),
        .az     (az),
        .aw     (aw),
        .bx     (bx),
        .by     (by),
        .bz     (bz),
        .bw     (bw),
        .done   (done),
        .rx     (rx),
        .ry     (ry),
        .rz     (rz),
        .rw     (rw)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // round to nearest, ties up, then clamp to the component range
    function automatic longint round_sat(input longint acc);
        longint v;
        v = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
        if (v > COMP_MAX)
            v = COMP_MAX;
        else if (v < COMP_MIN)
            v = COMP_MIN;
        return v;
    endfunction

    task automatic hamilton(input longint px, py, pz, pw, qx, qy, qz, qw,
                            output longint ox, oy, oz, ow);
        ox = round_sat(pw * qx + px * qw + py * qz - pz * qy);
        oy = round_sat(pw * qy - px * qz + py * qw + pz * qx);
        oz = round_sat(pw * qz + px * qy - py * qx + pz * qw);
        ow = round_sat(pw * qw - px * qx - py * qy - pz * qz);
    endtask

    task automatic predict_quat(input item_t it, output quat_res_t r);
        longint a0, a1, a2, a3, b0, b1, b2, b3;
        longint t0, t1, t2, t3, o0, o1, o2, o3;
        a0 = $signed(it.ax);
        a1 = $signed(it.ay);
        a2 = $signed(it.az);
        a3 = $signed(it.aw);
        b0 = $signed(it.bx);
        b1 = $signed(it.by);
        b2 = $signed(it.bz);
        b3 = $signed(it.bw);
        o0 = 0;
        o1 = 0;
        o2 = 0;
        o3 = 0;
        case (it.op)
            ACT_MUL:
                hamilton(a0, a1, a2, a3, b0, b1, b2, b3, o0, o1, o2, o3);
            ACT_ROT:
            begin
                hamilton(a0, a1, a2, a3, b0, b1, b2, 0, t0, t1, t2, t3);
                hamilton(t0, t1, t2, t3, -a0, -a1, -a2, a3, o0, o1, o2, o3);
                o3 = 0;
            end
            ACT_IROT:
            begin
                hamilton(-a0, -a1, -a2, a3, b0, b1, b2, 0, t0, t1, t2, t3);
                hamilton(t0, t1, t2, t3, a0, a1, a2, a3, o0, o1, o2, o3);
                o3 = 0;
            end
            ACT_DOT:
                o3 = round_sat(a0 * b0 + a1 * b1 + a2 * b2 + a3 * b3);
            ACT_CONJ:
            begin
                o0 = (-a0 > COMP_MAX) ? COMP_MAX : -a0;
                o1 = (-a1 > COMP_MAX) ? COMP_MAX : -a1;
                o2 = (-a2 > COMP_MAX) ? COMP_MAX : -a2;
                o3 = a3;
            end
            default:
                ;
        endcase
        r.x = o0[COMP-1:0];
        r.y = o1[COMP-1:0];
        r.z = o2[COMP-1:0];
        r.w = o3[COMP-1:0];
    endtask

    function automatic item_t make_item(input logic [ACT_W-1:0] op,
                                        input int xa, ya, za, wa, xb, yb, zb, wb);
        item_t it;
        it.op = op;
        it.ax = COMP'(xa);
        it.ay = COMP'(ya);
        it.az = COMP'(za);
        it.aw = COMP'(wa);
        it.bx = COMP'(xb);
        it.by = COMP'(yb);
        it.bz = COMP'(zb);
        it.bw = COMP'(wb);
        return it;
    endfunction

    // mostly unit-range values, plenty of full-range ones, some corners
    function automatic int rand_comp();
        int v;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: v = Q_MIN;
                    1: v = Q_MAX;
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
            1, 2, 3:
                v = int'($urandom_range(0, (1 << COMP) - 1)) + Q_MIN;
            default:
                v = int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
        endcase
        return v;
    endfunction

    task automatic check_field(input string name, input logic [COMP-1:0] want, got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("mismatch in %s of result %0d: expected %0d, got %0d",
                         name, results_checked, $signed(want), $signed(got));
        end
    endtask

    always @(negedge clk)
    begin : driver
        item_t nxt;
        if (rst_n && (!start || taken))
        begin
            if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left--;
            end
            else if (pending_beats.size() > 0)
            begin
                nxt = pending_beats.pop_front();
                action <= nxt.op;
                ax <= nxt.ax;
                ay <= nxt.ay;
                az <= nxt.az;
                aw <= nxt.aw;
                bx <= nxt.bx;
                by <= nxt.by;
                bz <= nxt.bz;
                bw <= nxt.bw;
                start <= 1'b1;
                gap_left = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 63) == 0)
                    burst_mode = !burst_mode;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        quat_res_t want;
        quat_res_t got;
        if (!rst_n)
        begin
            taken <= 1'b0;
            idle_cycles = 0;
        end
        else
        begin
            taken <= start && !busy;
            if (start && !busy)
            begin
                predict_quat(item_t'{action, ax, ay, az, aw, bx, by, bz, bw}, want);
                expected_quats.push_back(want);
                beats_taken++;
                action_count[action]++;
            end
            if (done)
            begin
                got = quat_res_t'{rx, ry, rz, rw};
                if (expected_quats.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result beat: %0d %0d %0d %0d",
                                 rx, ry, rz, rw);
                end
                else
                begin
                    want = expected_quats.pop_front();
                    check_field("rx", want.x, got.x);
                    check_field("ry", want.y, got.y);
                    check_field("rz", want.z, got.z);
                    check_field("rw", want.w, got.w);
                    results_checked++;
                end
            end
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         idle_cycles, expected_quats.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_MUL;
        ax = '0;
        ay = '0;
        az = '0;
        aw = '0;
        bx = '0;
        by = '0;
        bz = '0;
        bw = '0;
        gap_left = 0;
        burst_mode = 1'b0;
        beats_taken = 0;
        results_checked = 0;
        mismatches = 0;
        foreach (action_count[i])
            action_count[i] = 0;

        pending_beats.push_back(make_item(ACT_MUL, 0, 0, 0, Q_ONE, 1234, -2345, 3456, -4567));
        pending_beats.push_back(make_item(ACT_MUL, Q_ONE, 0, 0, 0, 0, Q_ONE, 0, 0));
        pending_beats.push_back(make_item(ACT_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                          Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        pending_beats.push_back(make_item(ACT_MUL, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                          Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        // half-LSB ties, both signs
        pending_beats.push_back(make_item(ACT_MUL, 0, 0, 0, 1, 0, 0, 0, Q_ONE / 2));
        pending_beats.push_back(make_item(ACT_MUL, 0, 0, 0, 1, 0, 0, 0, -Q_ONE / 2));
        pending_beats.push_back(make_item(ACT_ROT, 0, 0, COS45, COS45, Q_ONE, 0, 0, Q_MAX));
        pending_beats.push_back(make_item(ACT_ROT, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                          Q_MAX, Q_MAX, Q_MAX, Q_MIN));
        pending_beats.push_back(make_item(ACT_ROT, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                          Q_MIN, Q_MAX, Q_MIN, Q_MAX));
        pending_beats.push_back(make_item(ACT_IROT, 0, 0, COS45, COS45, Q_ONE, 0, 0, Q_MIN));
        pending_beats.push_back(make_item(ACT_IROT, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                          Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        pending_beats.push_back(make_item(ACT_DOT, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                          Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        pending_beats.push_back(make_item(ACT_DOT, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                          Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        pending_beats.push_back(make_item(ACT_DOT, 1, 0, 0, 0, Q_ONE / 2, 0, 0, 0));
        pending_beats.push_back(make_item(ACT_DOT, -1, 0, 0, 0, Q_ONE / 2, 5, 5, 5));
        pending_beats.push_back(make_item(ACT_CONJ, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                          Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        pending_beats.push_back(make_item(ACT_CONJ, Q_MAX, -1, 0, Q_MAX, 17, -17, 3, -3));
        pending_beats.push_back(make_item(ACT_SPARE_LO, Q_MIN, Q_MAX, -1, 1,
                                          Q_MAX, Q_MIN, 1, -1));
        pending_beats.push_back(make_item(ACT_SPARE_MID, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                                          Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        pending_beats.push_back(make_item(ACT_SPARE_HI, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                          Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        repeat (RANDOM_ITEMS)
            pending_beats.push_back(make_item(ACT_W'($urandom_range(0, 7)),
                                              rand_comp(), rand_comp(), rand_comp(),
                                              rand_comp(), rand_comp(), rand_comp(),
                                              rand_comp(), rand_comp()));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_beats.size() > 0 || start || expected_quats.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d beats, %0d results checked, %0d mismatches", beats_taken,
                 results_checked, mismatches);
        $display("per action: mul %0d rot %0d irot %0d dot %0d conj %0d unused %0d",
                 action_count[ACT_MUL], action_count[ACT_ROT], action_count[ACT_IROT],
                 action_count[ACT_DOT], action_count[ACT_CONJ],
                 action_count[ACT_SPARE_LO] + action_count[ACT_SPARE_MID]
                 + action_count[ACT_SPARE_HI]);
        if (mismatches == 0 && expected_quats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
